// ----- design/sts_pkg.sv -----
`timescale 1ns / 1ps
package sts_pkg;

    localparam int TRAILER_BYTES = 8192;
    localparam int HEADER_BYTES  = 8;

    localparam int AW    = $clog2(TRAILER_BYTES);
    localparam int CW    = $clog2(TRAILER_BYTES + 1);
    localparam int SIG_W = 13;
    localparam int PADW  = ((CW > SIG_W) ? CW : SIG_W) + 1;
    localparam int HDR_W = HEADER_BYTES * 8;

    localparam int CFG_DW = 32;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SCHEME  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SIG_LEN = 2'd2;

    localparam logic [SIG_W-1:0] SIG_LEN_RESET = 13'd7856;

    localparam logic KIND_IMAGE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LENGTH  = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_SCHEME  = 3'd3;
    localparam logic [2:0] ST_PADDING = 3'd4;

    typedef struct packed {
        logic [31:0]      magic_word;
        logic [15:0]      scheme_id;
        logic [SIG_W-1:0] signature_length;
    } t_cfg;

endpackage

// ----- design/signed_trailer_splitter_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid, o_in_stall  i_mode, i_data_byte
// output    out        o_out_valid, i_out_stall o_kind, o_image_byte, o_status,
//                                               o_image_length
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// While the window fills, a data beat is written to the memory and the input does not stall;
// once the window is full, the input stalls until the oldest byte, fetched by the registered
// read of the window memory, has been loaded into the output register.
// An end-of-stream beat on a full window walks the memory through its single read port: the
// eight header bytes, then each padding byte if the header matches, then the status beat; a
// short stream goes straight to the status beat.
// Reset is synchronous and active low; it clears the counters and restores the
// register defaults, while the window memory keeps its contents and the fill count
// tells which entries are held.
// A stalled result waits in the output register while the next input beat is taken.
module signed_trailer_splitter_top
    import sts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [7:0]        i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kind,
    output logic [7:0]        o_image_byte,
    output logic [2:0]        o_status,
    output logic [31:0]       o_image_length,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg          r_cfg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word       <= '0;
            r_cfg.scheme_id        <= '0;
            r_cfg.signature_length <= SIG_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAGIC:   r_cfg.magic_word       <= i_cfg_data[31:0];
                REG_SCHEME:  r_cfg.scheme_id        <= i_cfg_data[15:0];
                REG_SIG_LEN: r_cfg.signature_length <= i_cfg_data[SIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sts_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_image_byte   (o_image_byte),
        .o_status       (o_status),
        .o_image_length (o_image_length),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    sts_ram #(
        .WIDTH (8),
        .DEPTH (TRAILER_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ----- design/sts_ram.sv -----
`timescale 1ns / 1ps
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sts_core.sv -----
`timescale 1ns / 1ps
module sts_core
    import sts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_mode,
    input  logic [7:0]    i_data_byte,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_kind,
    output logic [7:0]    o_image_byte,
    output logic [2:0]    o_status,
    output logic [31:0]   o_image_length,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic [7:0]    o_ram_wdata,
    output logic          o_ram_re,
    output logic [AW-1:0] o_ram_raddr,
    input  logic [7:0]    i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_HDR,
        S_PAD,
        S_STAT
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_oldest, n_oldest;
    logic [31:0]      r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_epos, n_epos;
    logic             r_evalid, n_evalid;
    logic             r_elast, n_elast;
    logic [HDR_W-1:0] r_hdr, n_hdr;
    logic [2:0]       r_st, n_st;
    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_byte, n_byte;
    logic [2:0]       r_status, n_status;
    logic [31:0]      r_len, n_len;

    logic             in_accept;
    logic             out_free;
    logic             full;
    logic [CW:0]      slot_sum;
    logic [CW:0]      slot_wrap;
    logic [AW-1:0]    slot;
    logic [HDR_W-1:0] hdr_shift;
    logic [PADW-1:0]  pad_start;
    logic [31:0]      count_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign full       = (r_fill == CW'(TRAILER_BYTES));
    assign count_inc  = (r_count == 32'hFFFF_FFFF) ? r_count : r_count + 32'd1;

    assign slot_sum  = {{(CW + 1 - AW){1'b0}}, r_oldest} + {1'b0, r_pos};
    assign slot_wrap = (slot_sum >= (CW + 1)'(TRAILER_BYTES)) ?
                       slot_sum - (CW + 1)'(TRAILER_BYTES) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    assign hdr_shift = {i_ram_rdata, r_hdr[HDR_W-1:8]};
    assign pad_start = PADW'(HEADER_BYTES) + PADW'(i_cfg.signature_length);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_pos       = r_pos;
        n_epos      = r_epos;
        n_evalid    = 1'b0;
        n_elast     = r_elast;
        n_hdr       = r_hdr;
        n_st        = r_st;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_status    = r_status;
        n_len       = r_len;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_oldest;
        o_ram_wdata = i_data_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = slot;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_mode == MODE_EOS) begin
                        n_pos = '0;
                        if (full) begin
                            n_state = S_HDR;
                        end else begin
                            n_st    = ST_LENGTH;
                            n_state = S_STAT;
                        end
                    end else if (!full) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_fill[AW-1:0];
                        n_fill      = r_fill + 1'b1;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_oldest;
                        n_oldest    = (r_oldest == AW'(TRAILER_BYTES - 1)) ?
                                      '0 : r_oldest + 1'b1;
                        n_count     = count_inc;
                        n_state     = S_REL;
                    end
                end
            end
            S_REL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_IMAGE;
                    n_byte      = i_ram_rdata;
                    n_status    = ST_OK;
                    n_len       = r_count;
                    n_state     = S_IDLE;
                end
            end
            S_HDR: begin
                if (r_pos < CW'(HEADER_BYTES)) begin
                    o_ram_re = 1'b1;
                    n_evalid = 1'b1;
                    n_epos   = r_pos;
                    n_pos    = r_pos + 1'b1;
                end
                if (r_evalid) begin
                    n_hdr = hdr_shift;
                    if (r_epos == CW'(HEADER_BYTES - 1)) begin
                        n_evalid = 1'b0;
                        if (hdr_shift[31:0] != i_cfg.magic_word) begin
                            n_st    = ST_MAGIC;
                            n_state = S_STAT;
                        end else if (hdr_shift[47:32] != i_cfg.scheme_id) begin
                            n_st    = ST_SCHEME;
                            n_state = S_STAT;
                        end else if (hdr_shift[63:48] !=
                                     {3'b000, i_cfg.signature_length}) begin
                            n_st    = ST_LENGTH;
                            n_state = S_STAT;
                        end else if (pad_start >= PADW'(TRAILER_BYTES)) begin
                            n_st    = ST_OK;
                            n_state = S_STAT;
                        end else begin
                            n_pos   = pad_start[CW-1:0];
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                if (r_pos < CW'(TRAILER_BYTES)) begin
                    o_ram_re = 1'b1;
                    n_evalid = 1'b1;
                    n_elast  = (r_pos == CW'(TRAILER_BYTES - 1));
                    n_pos    = r_pos + 1'b1;
                end
                if (r_evalid) begin
                    if (i_ram_rdata != 8'd0) begin
                        n_evalid = 1'b0;
                        n_st     = ST_PADDING;
                        n_state  = S_STAT;
                    end else if (r_elast) begin
                        n_evalid = 1'b0;
                        n_st     = ST_OK;
                        n_state  = S_STAT;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_STATUS;
                    n_byte      = 8'd0;
                    n_status    = r_st;
                    n_len       = r_count;
                    n_fill      = '0;
                    n_oldest    = '0;
                    n_count     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_evalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_evalid    <= n_evalid;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_epos   <= n_epos;
        r_elast  <= n_elast;
        r_hdr    <= n_hdr;
        r_st     <= n_st;
        r_kind   <= n_kind;
        r_byte   <= n_byte;
        r_status <= n_status;
        r_len    <= n_len;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_image_byte   = r_byte;
    assign o_status       = r_status;
    assign o_image_length = r_len;

endmodule
